// File: sv/avralu_pkg.sv
// Shared types and constants for the AVR ALU and register file block.
// Holds the operation codes, the beat payload structs and the flag bit positions.
// No dependencies; every other file in this block imports it.

package avralu_pkg;

    // Operation codes carried in the request beat.
    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,
        OP_ADC  = 5'd1,
        OP_SUB  = 5'd2,
        OP_SUBI = 5'd3,
        OP_SBC  = 5'd4,
        OP_SBCI = 5'd5,
        OP_AND  = 5'd6,
        OP_ANDI = 5'd7,
        OP_OR   = 5'd8,
        OP_ORI  = 5'd9,
        OP_EOR  = 5'd10,
        OP_COM  = 5'd11,
        OP_NEG  = 5'd12,
        OP_SBR  = 5'd13,
        OP_CBR  = 5'd14,
        OP_INC  = 5'd15,
        OP_DEC  = 5'd16,
        OP_TST  = 5'd17,
        OP_CLR  = 5'd18,
        OP_SER  = 5'd19,
        OP_MUL  = 5'd20,
        OP_MULS = 5'd21
    } alu_op_t;

    // Status register bit positions.
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_V = 3;
    localparam int unsigned FLAG_S = 4;
    localparam int unsigned FLAG_H = 5;

    // Byte constants used by the flag logic.
    localparam logic [7:0] BYTE_POS_MAX = 8'h7f;
    localparam logic [7:0] BYTE_NEG_MIN = 8'h80;
    localparam logic [7:0] BYTE_ONES    = 8'hff;

    // The register file is kept as 16 rows of two registers each.
    localparam int unsigned RF_ROWS = 16;
    typedef logic [3:0]  row_addr_t;
    typedef logic [15:0] row_t;
    localparam row_addr_t ROW_PRODUCT = 4'd0;

    // Request beat.
    typedef struct packed {
        logic [4:0] op;
        logic [4:0] dest_index;
        logic [4:0] source_index;
        logic [7:0] immediate;
    } alu_req_t;

    // Response beat.
    typedef struct packed {
        logic [7:0] result_value;
        logic [7:0] product_high;
        logic [7:0] status_out;
        logic       bad_opcode;
    } alu_rsp_t;

    // Execution unit outcome handed to the control logic.
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] product_high;
        logic [7:0] flags;
        logic       bad;
        logic       is_mul;
    } alu_res_t;

endpackage

// File: sv/avralu_if.sv
// Valid/ready channel interfaces for the AVR ALU request and response beats.
// Depends on avralu_pkg for the payload structs.

interface avralu_req_if;
    import avralu_pkg::*;

    logic     valid;
    logic     ready;
    alu_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface avralu_rsp_if;
    import avralu_pkg::*;

    logic     valid;
    logic     ready;
    alu_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/avr_alu_register_file.sv
// Top level of the AVR ALU with its 32-entry register file and status register.
// Depends on avralu_pkg, avralu_if, avralu_regfile and avralu_exec.
//
// Usage:
//   req carries one instruction per beat (op, dest_index, source_index, immediate).
//   rsp returns one beat per instruction, in order: result byte, product high byte,
//   the status register after the instruction, and a flag for an unknown opcode.
//   Both channels use valid/ready; a beat moves when both are high at a clock edge.
// Timing:
//   A request beat taken at an edge has its register operands read from the register
//   file storage at that edge. The instruction executes in the next cycle, and its
//   response beat is registered and presented when it leaves the execute stage. One
//   instruction is taken every cycle while rsp is not held; the rate is set by the
//   registered read of the register file and the execute-and-write-back stage after it.
// Reset:
//   rst_n clears the status register, the per-row valid bits (so every register reads
//   as zero) and the pipeline. No clearing pass is needed; requests are taken at once.
// Stall:
//   While rsp is held, one instruction waits in the execute stage and req.ready drops.

module avr_alu_register_file (
    input  logic         clk,
    input  logic         rst_n,
    avralu_req_if.sink   req,
    avralu_rsp_if.source rsp
);
    import avralu_pkg::*;

    logic       req_go;
    logic       s1_go;
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [4:0] s1_op_reg;
    logic [4:0] s1_dest_reg;
    logic       s1_src_lsb_reg;
    logic [7:0] s1_imm_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    alu_rsp_t   out_data_reg;
    logic [7:0] flags_reg;
    logic [7:0] flags_next;
    row_t       row_a;
    row_t       row_b;
    logic [7:0] rd_byte;
    logic [7:0] rr_byte;
    alu_res_t   x_res;
    logic       wr_en;
    row_addr_t  wr_row;
    row_t       wr_data;

    // Handshake control.
    assign s1_go     = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_go;
    assign req_go    = req.valid && req.ready;

    // Register file storage and its operand reads.
    avralu_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (req_go),
        .rd_row_a  (req.payload.dest_index[4:1]),
        .rd_row_b  (req.payload.source_index[4:1]),
        .rd_data_a (row_a),
        .rd_data_b (row_b),
        .wr_en     (wr_en),
        .wr_row    (wr_row),
        .wr_data   (wr_data)
    );

    // Operand byte selection within the row.
    assign rd_byte = s1_dest_reg[0] ? row_a[15:8] : row_a[7:0];
    assign rr_byte = s1_src_lsb_reg ? row_b[15:8] : row_b[7:0];

    avralu_exec u_exec (
        .op        (s1_op_reg),
        .rd        (rd_byte),
        .rr        (rr_byte),
        .immediate (s1_imm_reg),
        .flags_in  (flags_reg),
        .res       (x_res)
    );

    // Write back: a multiply fills the whole first row, otherwise one byte is merged.
    always_comb
    begin
        wr_en = s1_go && !x_res.bad;
        if (x_res.is_mul)
        begin
            wr_row  = ROW_PRODUCT;
            wr_data = {x_res.product_high, x_res.result};
        end
        else
        begin
            wr_row  = s1_dest_reg[4:1];
            wr_data = s1_dest_reg[0] ? {x_res.result, row_a[7:0]}
                                     : {row_a[15:8], x_res.result};
        end
    end

    // Next state of the control registers.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_go)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        flags_next = s1_go ? x_res.flags : flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flags_reg     <= flags_next;
        end
    end

    // Execute stage operands held alongside the registered read data.
    always_ff @(posedge clk)
    begin
        if (req_go)
        begin
            s1_op_reg      <= req.payload.op;
            s1_dest_reg    <= req.payload.dest_index;
            s1_src_lsb_reg <= req.payload.source_index[0];
            s1_imm_reg     <= req.payload.immediate;
        end
    end

    // Response output register.
    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_data_reg.result_value <= x_res.result;
            out_data_reg.product_high <= x_res.product_high;
            out_data_reg.status_out   <= x_res.flags;
            out_data_reg.bad_opcode   <= x_res.bad;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

`ifndef ASSERT_OFF
    // An instruction blocked by a held response stays in the execute stage.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg)
        else $error("execute stage lost an instruction while stalled");

    // An unknown opcode leaves the status register as it was.
    a_bad_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && x_res.bad |=> $stable(flags_reg))
        else $error("unknown opcode changed the status register");

    // The T and I bits are never touched by any instruction.
    a_ti_stable: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $stable(flags_reg[7:6]))
        else $error("T or I flag changed");

    // A rejected instruction reports zero result bytes.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.bad_opcode |->
            out_data_reg.result_value == 8'd0 && out_data_reg.product_high == 8'd0)
        else $error("unknown opcode produced a nonzero result");
`endif

endmodule

// File: sv/avralu_regfile.sv
// Register file storage: 16 rows of two 8-bit registers, two read ports, one write port.
// Reads are registered and see a write to the same row at the same edge.
// Depends on avralu_pkg for the row types.

module avralu_regfile (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  avralu_pkg::row_addr_t rd_row_a,
    input  avralu_pkg::row_addr_t rd_row_b,
    output avralu_pkg::row_t  rd_data_a,
    output avralu_pkg::row_t  rd_data_b,
    input  logic              wr_en,
    input  avralu_pkg::row_addr_t wr_row,
    input  avralu_pkg::row_t  wr_data
);
    import avralu_pkg::*;

    row_t                 mem [RF_ROWS];
    logic [RF_ROWS-1:0]   row_valid_reg;
    logic [RF_ROWS-1:0]   row_valid_next;
    row_t                 data_a_reg;
    row_t                 data_b_reg;
    logic                 valid_a_reg;
    logic                 valid_b_reg;
    logic                 hit_a;
    logic                 hit_b;

    assign hit_a = wr_en && (wr_row == rd_row_a);
    assign hit_b = wr_en && (wr_row == rd_row_b);

    // A row that was never written reads as zero.
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (wr_en)
        begin
            row_valid_next[wr_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (rd_en)
            begin
                valid_a_reg <= hit_a || row_valid_reg[rd_row_a];
                valid_b_reg <= hit_b || row_valid_reg[rd_row_b];
            end
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_data;
        end
    end

    // Registered reads with write bypass on a same-row collision.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a_reg <= hit_a ? wr_data : mem[rd_row_a];
            data_b_reg <= hit_b ? wr_data : mem[rd_row_b];
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : '0;
    assign rd_data_b = valid_b_reg ? data_b_reg : '0;

endmodule

// File: sv/avralu_exec.sv
// Combinational execution unit: adder, subtractor, logic ops and 8x8 multiplier.
// Produces the result bytes and the updated status flags for one instruction.
// Depends on avralu_pkg for operation codes, flag positions and the result struct.

module avralu_exec (
    input  logic [4:0]           op,
    input  logic [7:0]           rd,
    input  logic [7:0]           rr,
    input  logic [7:0]           immediate,
    input  logic [7:0]           flags_in,
    output avralu_pkg::alu_res_t res
);
    import avralu_pkg::*;

    alu_op_t            op_code;
    logic               cin;
    logic [7:0]         sub_b;
    logic               add_cin;
    logic               sub_cin;
    logic               sub_chain;
    logic [8:0]         add_sum;
    logic [4:0]         add_half;
    logic [7:0]         add_r;
    logic               add_v;
    logic [8:0]         sub_diff;
    logic [4:0]         sub_half;
    logic [7:0]         sub_r;
    logic               sub_v;
    logic [7:0]         neg_r;
    logic [7:0]         inc_r;
    logic [7:0]         dec_r;
    logic signed [8:0]  mul_a;
    logic signed [8:0]  mul_b;
    logic signed [17:0] mul_full;
    logic [15:0]        product;
    logic               oldc;
    logic               oldh;

    // Builds Z, N, V, S from the result; C and H as given; T and I kept.
    function automatic logic [7:0] make_flags(
        input logic [7:0] old,
        input logic [7:0] r,
        input logic       v,
        input logic       c,
        input logic       h,
        input logic       z_chain
    );
        logic [7:0] f;
        f         = old;
        f[FLAG_C] = c;
        f[FLAG_Z] = (r == 8'd0) && (!z_chain || old[FLAG_Z]);
        f[FLAG_N] = r[7];
        f[FLAG_V] = v;
        f[FLAG_S] = r[7] ^ v;
        f[FLAG_H] = h;
        return f;
    endfunction

    assign op_code = alu_op_t'(op);
    assign cin     = flags_in[FLAG_C];
    assign oldc    = flags_in[FLAG_C];
    assign oldh    = flags_in[FLAG_H];

    // Operand and carry selection for the shared add and subtract paths.
    assign sub_b     = ((op_code == OP_SUBI) || (op_code == OP_SBCI)) ? immediate : rr;
    assign add_cin   = (op_code == OP_ADC) ? cin : 1'b0;
    assign sub_chain = (op_code == OP_SBC) || (op_code == OP_SBCI);
    assign sub_cin   = sub_chain ? cin : 1'b0;

    // Adder with half carry and overflow.
    assign add_sum  = {1'b0, rd} + {1'b0, rr} + {8'd0, add_cin};
    assign add_half = {1'b0, rd[3:0]} + {1'b0, rr[3:0]} + {4'd0, add_cin};
    assign add_r    = add_sum[7:0];
    assign add_v    = (~(rd[7] ^ rr[7])) & (rd[7] ^ add_r[7]);

    // Subtractor; the sign bit of the widened difference is the borrow.
    assign sub_diff = {1'b0, rd} - {1'b0, sub_b} - {8'd0, sub_cin};
    assign sub_half = {1'b0, rd[3:0]} - {1'b0, sub_b[3:0]} - {4'd0, sub_cin};
    assign sub_r    = sub_diff[7:0];
    assign sub_v    = (rd[7] ^ sub_b[7]) & (rd[7] ^ sub_r[7]);

    assign neg_r = 8'd0 - rd;
    assign inc_r = rd + 8'd1;
    assign dec_r = rd - 8'd1;

    // One signed 9x9 multiplier serves both MUL and MULS.
    assign mul_a    = {(op_code == OP_MULS) & rd[7], rd};
    assign mul_b    = {(op_code == OP_MULS) & rr[7], rr};
    assign mul_full = mul_a * mul_b;
    assign product  = mul_full[15:0];

    // Instruction decode and flag selection.
    always_comb
    begin
        res.result       = 8'd0;
        res.product_high = 8'd0;
        res.flags        = flags_in;
        res.bad          = 1'b0;
        res.is_mul       = 1'b0;
        unique case (op_code)
            OP_ADD, OP_ADC:
            begin
                res.result = add_r;
                res.flags  = make_flags(flags_in, add_r, add_v, add_sum[8], add_half[4], 1'b0);
            end
            OP_SUB, OP_SUBI:
            begin
                res.result = sub_r;
                res.flags  = make_flags(flags_in, sub_r, sub_v, sub_diff[8], sub_half[4], 1'b0);
            end
            OP_SBC, OP_SBCI:
            begin
                res.result = sub_r;
                res.flags  = make_flags(flags_in, sub_r, sub_v, sub_diff[8], sub_half[4], 1'b1);
            end
            OP_AND:
            begin
                res.result = rd & rr;
                res.flags  = make_flags(flags_in, rd & rr, 1'b0, oldc, oldh, 1'b0);
            end
            OP_ANDI:
            begin
                res.result = rd & immediate;
                res.flags  = make_flags(flags_in, rd & immediate, 1'b0, oldc, oldh, 1'b0);
            end
            OP_OR:
            begin
                res.result = rd | rr;
                res.flags  = make_flags(flags_in, rd | rr, 1'b0, oldc, oldh, 1'b0);
            end
            OP_ORI, OP_SBR:
            begin
                res.result = rd | immediate;
                res.flags  = make_flags(flags_in, rd | immediate, 1'b0, oldc, oldh, 1'b0);
            end
            OP_EOR:
            begin
                res.result = rd ^ rr;
                res.flags  = make_flags(flags_in, rd ^ rr, 1'b0, oldc, oldh, 1'b0);
            end
            OP_COM:
            begin
                res.result = ~rd;
                res.flags  = make_flags(flags_in, ~rd, 1'b0, 1'b1, oldh, 1'b0);
            end
            OP_NEG:
            begin
                res.result = neg_r;
                res.flags  = make_flags(flags_in, neg_r, neg_r == BYTE_NEG_MIN,
                                        neg_r != 8'd0, neg_r[3] | rd[3], 1'b0);
            end
            OP_CBR:
            begin
                res.result = rd & ~immediate;
                res.flags  = make_flags(flags_in, rd & ~immediate, 1'b0, oldc, oldh, 1'b0);
            end
            OP_INC:
            begin
                res.result = inc_r;
                res.flags  = make_flags(flags_in, inc_r, rd == BYTE_POS_MAX, oldc, oldh, 1'b0);
            end
            OP_DEC:
            begin
                res.result = dec_r;
                res.flags  = make_flags(flags_in, dec_r, rd == BYTE_NEG_MIN, oldc, oldh, 1'b0);
            end
            OP_TST:
            begin
                res.result = rd;
                res.flags  = make_flags(flags_in, rd, 1'b0, oldc, oldh, 1'b0);
            end
            OP_CLR:
            begin
                res.result = 8'd0;
                res.flags  = make_flags(flags_in, 8'd0, 1'b0, oldc, oldh, 1'b0);
            end
            OP_SER:
            begin
                res.result = BYTE_ONES;
            end
            OP_MUL, OP_MULS:
            begin
                res.result        = product[7:0];
                res.product_high  = product[15:8];
                res.is_mul        = 1'b1;
                res.flags[FLAG_C] = product[15];
                res.flags[FLAG_Z] = (product == 16'd0);
            end
            default:
            begin
                res.bad = 1'b1;
            end
        endcase
    end

endmodule

// File: bench/tb_avr_alu_register_file.sv
// Self-checking testbench for the AVR ALU with its register file and status register.
// Needs avralu_pkg, avralu_req_if, avralu_rsp_if and the avr_alu_register_file top level.
// Directed and random instruction streams are checked against a predictor kept here.
`timescale 1ns / 1ps

module tb_avr_alu_register_file;
    import avralu_pkg::*;

    localparam int unsigned OP_CODE_MAX    = 31;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;
    localparam int unsigned RANDOM_STEPS   = 170;

    logic clk = 1'b0;
    logic rst_n;

    avralu_req_if req_ch ();
    avralu_rsp_if rsp_ch ();

    avr_alu_register_file uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    // Predicted architectural state.
    logic [7:0] gpr [32];
    logic [7:0] sreg;

    // Responses still owed by the block, oldest first.
    alu_rsp_t owed_rsp_q [$];

    // Knobs that the test tasks set per phase.
    bit no_idle;
    bit stall_free;

    int unsigned error_count;
    int unsigned instr_count;
    int unsigned unknown_count;
    int unsigned checked_count;
    logic [OP_CODE_MAX:0] ops_hit;

    // Build a status byte from a result and the flags that the operation supplies.
    function automatic logic [7:0] make_sreg(input logic [7:0] prev, input logic [7:0] res,
                                             input logic ovf, input logic carry,
                                             input logic half, input logic z_chain);
        logic [7:0] f;
        f = {prev[7:6], 6'b0};
        f[FLAG_C] = carry;
        f[FLAG_Z] = (res == 8'h00) && (!z_chain || prev[FLAG_Z]);
        f[FLAG_N] = res[7];
        f[FLAG_V] = ovf;
        f[FLAG_S] = res[7] ^ ovf;
        f[FLAG_H] = half;
        return f;
    endfunction

    // Execute one instruction on the predicted state and return the response it owes.
    function automatic alu_rsp_t execute_instr(input alu_req_t item);
        alu_rsp_t    outcome;
        alu_op_t     op;
        logic [7:0]  rd;
        logic [7:0]  rr;
        logic [7:0]  operand;
        logic [7:0]  res;
        logic [7:0]  hi;
        logic [7:0]  f;
        logic [8:0]  wide;
        logic [4:0]  nib;
        logic [15:0] prod;
        logic        c_in;
        logic        is_logic;
        logic        is_mul;
        logic        bad;
        op       = alu_op_t'(item.op);
        rd       = gpr[item.dest_index];
        rr       = gpr[item.source_index];
        f        = sreg;
        res      = 8'h00;
        hi       = 8'h00;
        is_logic = 1'b0;
        is_mul   = 1'b0;
        bad      = 1'b0;
        case (op)
            OP_ADD, OP_ADC:
            begin
                c_in = (op == OP_ADC) ? sreg[FLAG_C] : 1'b0;
                wide = {1'b0, rd} + {1'b0, rr} + {8'b0, c_in};
                nib  = {1'b0, rd[3:0]} + {1'b0, rr[3:0]} + {4'b0, c_in};
                res  = wide[7:0];
                f    = make_sreg(sreg, res, ~(rd[7] ^ rr[7]) & (rd[7] ^ res[7]),
                                 wide[8], nib[4], 1'b0);
            end
            OP_SUB, OP_SUBI, OP_SBC, OP_SBCI:
            begin
                operand = (op == OP_SUBI || op == OP_SBCI) ? item.immediate : rr;
                c_in    = (op == OP_SBC || op == OP_SBCI) ? sreg[FLAG_C] : 1'b0;
                // Bit 8 and bit 4 of the widened differences are the borrows.
                wide = {1'b0, rd} - {1'b0, operand} - {8'b0, c_in};
                nib  = {1'b0, rd[3:0]} - {1'b0, operand[3:0]} - {4'b0, c_in};
                res  = wide[7:0];
                f    = make_sreg(sreg, res, (rd[7] ^ operand[7]) & (rd[7] ^ res[7]),
                                 wide[8], nib[4], op == OP_SBC || op == OP_SBCI);
            end
            OP_AND:
            begin
                res      = rd & rr;
                is_logic = 1'b1;
            end
            OP_ANDI:
            begin
                res      = rd & item.immediate;
                is_logic = 1'b1;
            end
            OP_OR:
            begin
                res      = rd | rr;
                is_logic = 1'b1;
            end
            OP_ORI:
            begin
                res      = rd | item.immediate;
                is_logic = 1'b1;
            end
            OP_EOR:
            begin
                res      = rd ^ rr;
                is_logic = 1'b1;
            end
            OP_SBR:
            begin
                res      = rd | item.immediate;
                is_logic = 1'b1;
            end
            OP_CBR:
            begin
                res      = rd & ~item.immediate;
                is_logic = 1'b1;
            end
            OP_TST:
            begin
                res      = rd;
                is_logic = 1'b1;
            end
            OP_CLR:
            begin
                res      = 8'h00;
                is_logic = 1'b1;
            end
            OP_COM:
            begin
                res = ~rd;
                f   = make_sreg(sreg, res, 1'b0, 1'b1, sreg[FLAG_H], 1'b0);
            end
            OP_NEG:
            begin
                res = 8'h00 - rd;
                f   = make_sreg(sreg, res, res == BYTE_NEG_MIN, res != 8'h00,
                                res[3] | rd[3], 1'b0);
            end
            OP_INC:
            begin
                res = rd + 8'h01;
                f   = make_sreg(sreg, res, rd == BYTE_POS_MAX, sreg[FLAG_C],
                                sreg[FLAG_H], 1'b0);
            end
            OP_DEC:
            begin
                res = rd - 8'h01;
                f   = make_sreg(sreg, res, rd == BYTE_NEG_MIN, sreg[FLAG_C],
                                sreg[FLAG_H], 1'b0);
            end
            OP_SER:
            begin
                res = BYTE_ONES;
            end
            OP_MUL, OP_MULS:
            begin
                if (op == OP_MUL)
                begin
                    prod = {8'b0, rd} * {8'b0, rr};
                end
                else
                begin
                    prod = 16'($signed({{8{rd[7]}}, rd}) * $signed({{8{rr[7]}}, rr}));
                end
                res       = prod[7:0];
                hi        = prod[15:8];
                f[FLAG_C] = prod[15];
                f[FLAG_Z] = (prod == 16'h0000);
                is_mul    = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        // Logic forms keep C and H and clear V.
        if (is_logic)
        begin
            f = make_sreg(sreg, res, 1'b0, sreg[FLAG_C], sreg[FLAG_H], 1'b0);
        end

        // Write back; an unknown opcode leaves the state alone.
        if (!bad)
        begin
            if (is_mul)
            begin
                gpr[0] = res;
                gpr[1] = hi;
            end
            else
            begin
                gpr[item.dest_index] = res;
            end
            sreg = f;
        end

        outcome.result_value = res;
        outcome.product_high = hi;
        outcome.status_out   = sreg;
        outcome.bad_opcode   = bad;
        return outcome;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            flag_error($sformatf("%s expected 0x%02h, got 0x%02h", name, want, got));
        end
    endtask

    // Predict on every accepted request beat and compare every accepted response beat.
    always @(posedge clk)
    begin
        alu_rsp_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                owed_rsp_q.push_back(execute_instr(req_ch.payload));
                instr_count++;
                ops_hit[req_ch.payload.op] = 1'b1;
                if (req_ch.payload.op > OP_MULS)
                begin
                    unknown_count++;
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    flag_error("response beat with no instruction outstanding");
                end
                else
                begin
                    want = owed_rsp_q.pop_front();
                    checked_count++;
                    check_field("result_value", want.result_value,
                                rsp_ch.payload.result_value);
                    check_field("product_high", want.product_high,
                                rsp_ch.payload.product_high);
                    check_field("status_out", want.status_out,
                                rsp_ch.payload.status_out);
                    check_field("bad_opcode", {7'b0, want.bad_opcode},
                                {7'b0, rsp_ch.payload.bad_opcode});
                end
            end
        end
    end

    // Response sink: random stalls, mostly short, sometimes long.
    initial
    begin
        int unsigned stall_left;
        int unsigned roll;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_free)
            begin
                rsp_ch.ready <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    rsp_ch.ready <= 1'b1;
                end
                else if (roll < 95)
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                else
                begin
                    rsp_ch.ready <= 1'b0;
                    stall_left = $urandom_range(5, 20);
                end
            end
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        int unsigned quiet_cycles;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles, %0d responses outstanding",
                     quiet_cycles, owed_rsp_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
        begin
            return 0;
        end
        else if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 20);
    endfunction

    // Send one instruction beat; returns at the edge where it is taken.
    task automatic issue_instr(input logic [4:0] op, input logic [4:0] dest,
                               input logic [4:0] src, input logic [7:0] imm);
        alu_req_t    beat;
        int unsigned gap;
        beat.op           = op;
        beat.dest_index   = dest;
        beat.source_index = src;
        beat.immediate    = imm;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    // Put a known byte into a register.
    task automatic load_reg(input logic [4:0] dest, input logic [7:0] value);
        issue_instr(OP_CLR, dest, 5'd0, 8'h00);
        issue_instr(OP_ORI, dest, 5'd0, value);
    endtask

    function automatic logic [4:0] pick_reg();
        // Half the picks land on a few registers so results feed straight back.
        if ($urandom_range(0, 1) == 1)
        begin
            return 5'($urandom_range(0, 3));
        end
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [7:0] pick_byte();
        logic [7:0] corners [6];
        corners = '{8'h00, 8'h01, 8'h0f, BYTE_POS_MAX, BYTE_NEG_MIN, BYTE_ONES};
        if ($urandom_range(0, 3) == 0)
        begin
            return corners[3'($urandom_range(0, 5))];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Carries, borrows, overflow at the signed limits and the chained zero flag.
    task automatic test_arith_extremes();
        issue_instr(OP_SUBI, 5'd2, 5'd0, BYTE_ONES);
        issue_instr(OP_ORI, 5'd16, 5'd0, BYTE_POS_MAX);
        issue_instr(OP_ADD, 5'd16, 5'd2, 8'h00);
        issue_instr(OP_DEC, 5'd16, 5'd0, 8'h00);
        issue_instr(OP_INC, 5'd16, 5'd0, 8'h00);
        issue_instr(OP_SER, 5'd31, 5'd0, 8'h00);
        issue_instr(OP_ADD, 5'd31, 5'd2, 8'h00);
        issue_instr(OP_ADC, 5'd2, 5'd2, 8'h00);
        issue_instr(OP_SUB, 5'd31, 5'd2, 8'h00);
        issue_instr(OP_SBC, 5'd31, 5'd31, 8'h00);
        issue_instr(OP_SUB, 5'd6, 5'd6, 8'h00);
        issue_instr(OP_SBC, 5'd6, 5'd6, 8'h00);
        issue_instr(OP_SBCI, 5'd6, 5'd0, 8'h00);
        issue_instr(OP_SBCI, 5'd0, 5'd31, BYTE_ONES);
        issue_instr(OP_NEG, 5'd16, 5'd0, 8'h00);
        issue_instr(OP_NEG, 5'd7, 5'd0, 8'h00);
    endtask

    // Every logic form but ORI, including the clear-bits mask and test-for-zero.
    task automatic test_logic_ops();
        issue_instr(OP_COM, 5'd7, 5'd0, 8'h00);
        issue_instr(OP_AND, 5'd7, 5'd16, 8'h00);
        issue_instr(OP_ANDI, 5'd31, 5'd0, 8'h0f);
        issue_instr(OP_OR, 5'd0, 5'd7, 8'h00);
        issue_instr(OP_EOR, 5'd7, 5'd7, 8'h00);
        issue_instr(OP_SBR, 5'd7, 5'd0, 8'h81);
        issue_instr(OP_CBR, 5'd7, 5'd0, 8'h01);
        issue_instr(OP_TST, 5'd7, 5'd0, 8'h00);
        issue_instr(OP_CLR, 5'd7, 5'd0, 8'h00);
    endtask

    // Unsigned and signed products at the corners, and a zero product.
    task automatic test_multiply();
        issue_instr(OP_SER, 5'd20, 5'd0, 8'h00);
        issue_instr(OP_MUL, 5'd20, 5'd20, 8'h00);
        issue_instr(OP_ORI, 5'd21, 5'd0, BYTE_NEG_MIN);
        issue_instr(OP_MULS, 5'd21, 5'd21, 8'h00);
        issue_instr(OP_MULS, 5'd21, 5'd20, 8'h00);
        issue_instr(OP_MUL, 5'd22, 5'd20, 8'h00);
    endtask

    // Codes above the last operation must change nothing.
    task automatic test_unknown_opcodes();
        issue_instr(5'(int'(OP_MULS) + 1), 5'd20, 5'd21, BYTE_ONES);
        issue_instr(5'(OP_CODE_MAX), 5'd0, 5'd31, 8'h00);
    endtask

    // Mostly valid operations on random operands, with corner loads and unknown codes.
    task automatic run_random_mix(input int unsigned steps);
        int unsigned roll;
        repeat (steps)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                issue_instr(5'($urandom_range(int'(OP_MULS) + 1, OP_CODE_MAX)),
                            pick_reg(), pick_reg(), pick_byte());
            end
            else if (roll < 16)
            begin
                load_reg(pick_reg(), pick_byte());
            end
            else
            begin
                issue_instr(5'($urandom_range(0, int'(OP_MULS))), pick_reg(), pick_reg(),
                            pick_byte());
            end
        end
    endtask

    task automatic test_random_with_stalls();
        no_idle    = 1'b0;
        stall_free = 1'b0;
        run_random_mix(RANDOM_STEPS);
    endtask

    task automatic test_random_streaming();
        no_idle    = 1'b1;
        stall_free = 1'b1;
        run_random_mix(RANDOM_STEPS);
        no_idle    = 1'b0;
        stall_free = 1'b0;
    endtask

    initial
    begin
        foreach (gpr[i])
        begin
            gpr[i] = 8'h00;
        end
        sreg           = 8'h00;
        no_idle        = 1'b0;
        stall_free     = 1'b0;
        error_count    = 0;
        instr_count    = 0;
        unknown_count  = 0;
        checked_count  = 0;
        ops_hit        = '0;
        rst_n          = 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith_extremes();
        test_logic_ops();
        test_multiply();
        test_unknown_opcodes();
        test_random_with_stalls();
        test_random_streaming();

        // Drain the outstanding responses, then watch a few quiet cycles.
        // Wait for an edge first so the last accepted beat is already in the queue.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (owed_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("Ran %0d instructions (%0d with unknown codes, %0d distinct codes used)",
                 instr_count, unknown_count, $countones(ops_hit));
        $display("Checked %0d responses under random gaps and stalls; %0d field errors",
                 checked_count, error_count);
        if (error_count == 0 && owed_rsp_q.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
